/* hw/rtl/tpnf_pkg.sv */
package tpnf_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CFG_W_BITS     = 11;
  localparam int CFG_H_BITS     = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int WIDTH_RST      = 64;
  localparam int HEIGHT_RST     = 64;
  localparam int RECIP_SHIFT    = 16;

  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;
  localparam logic       KIND_PIXEL = 1'b0;
  localparam logic       KIND_FLUSH = 1'b1;
  localparam logic [7:0] OPAQUE     = 8'd255;

  typedef struct packed {
    logic accept;
    logic start;
    logic issue;
    logic accum;
    logic div_step;
    logic load;
  } tpnf_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic tap_last;
    logic ch_last;
    logic out_free;
  } tpnf_sts_t;

  // ceil(2^16 / n); exact quotient for sums below 2^12 and n up to 9
  function automatic logic [16:0] recip(input logic [3:0] n);
    logic [16:0] r;
    begin
      case (n)
        4'd1:    r = 17'd65536;
        4'd2:    r = 17'd32768;
        4'd3:    r = 17'd21846;
        4'd4:    r = 17'd16384;
        4'd5:    r = 17'd13108;
        4'd6:    r = 17'd10923;
        4'd7:    r = 17'd9363;
        4'd8:    r = 17'd8192;
        4'd9:    r = 17'd7282;
        default: r = 17'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* hw/rtl/tpnf_ram.sv */
module tpnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2052
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/tpnf_ctrl.sv */
module tpnf_ctrl
  import tpnf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tpnf_sts_t sts,
  output tpnf_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = in_tvalid && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.emit_req) begin
          cmd.start = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.issue = 1'b1;
        state_nxt = S_DATA;
      end
      S_DATA: begin
        cmd.accum = 1'b1;
        state_nxt = sts.tap_last ? S_DIV : S_ADDR;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.ch_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == S_ADDR)
    else $error("emit did not enter tap walk");
  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_IDLE)
    else $error("load did not return to idle");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.issue, cmd.accum, cmd.div_step, cmd.load}))
    else $error("overlapping datapath commands");

endmodule

/* hw/rtl/tpnf_dp.sv */
module tpnf_dp
  import tpnf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_kind,
  input  logic [31:0]              in_pix,
  input  tpnf_cmd_t                cmd,
  output tpnf_sts_t                sts,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [31:0]              out_tdata,
  output logic                     out_tlast
);

  localparam int S  = 2 * MAX_WIDTH + 4;
  localparam int AW = $clog2(S);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_WIDTH + 3);

  logic [CFG_W_BITS-1:0] width_r;
  logic [CFG_H_BITS-1:0] height_r;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [AW-1:0] wr_pos_r, rd_pos_r, rb_r, tap_addr;
  logic [PW-1:0] pending_r;
  logic [WW-1:0] in_col_r, out_col_r;
  logic [HW-1:0] in_row_r, out_row_r;
  logic [1:0]    dr_r, dc_r, ch_r;
  logic [3:0]    n_r;
  logic [11:0]   sr_r, sg_r, sb_r, sum_sel;
  logic [31:0]   ctr_r, rd_data;
  logic [7:0]    qr_r, qg_r, qb_r, q;
  logic [28:0]   prod;
  logic [AW:0]   tap_sum, rb_sum, rb_init;
  logic          pix, tap_in, fill, out_valid_r;
  logic [31:0]   out_data_r;
  logic          out_last_r;

  always_comb begin
    if (width_r == '0) eff_w = WW'(1);
    else if (32'(width_r) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if (height_r == '0) eff_h = HW'(1);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
    else eff_h = HW'(height_r);
  end

  assign pix = (in_kind == KIND_PIXEL);
  assign sts.emit_req = pix ? (32'(pending_r) > 32'(eff_w))
                            : (pending_r != '0 && in_col_r == '0 && in_row_r == '0);
  assign sts.tap_last = (dr_r == 2'd2) && (dc_r == 2'd2);
  assign sts.ch_last  = (ch_r == 2'd2);
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    tap_sum = {1'b0, rb_r} + (AW+1)'(dc_r);
    if (tap_sum >= (AW+1)'(S)) tap_sum = tap_sum - (AW+1)'(S);
    tap_addr = tap_sum[AW-1:0];
    rb_sum = {1'b0, rb_r} + (AW+1)'(eff_w);
    if (rb_sum >= (AW+1)'(S)) rb_sum = rb_sum - (AW+1)'(S);
    rb_init = {1'b0, rd_pos_r} + (AW+1)'(S) - (AW+1)'(eff_w) - (AW+1)'(1);
    if (rb_init >= (AW+1)'(S)) rb_init = rb_init - (AW+1)'(S);
    tap_in = !((dr_r == 2'd0) && (out_row_r == '0))
          && !((dr_r == 2'd2) && (32'(out_row_r) + 32'd1 >= 32'(eff_h)))
          && !((dc_r == 2'd0) && (out_col_r == '0))
          && !((dc_r == 2'd2) && (32'(out_col_r) + 32'd1 >= 32'(eff_w)));
    case (ch_r)
      2'd0:    sum_sel = sr_r;
      2'd1:    sum_sel = sg_r;
      default: sum_sel = sb_r;
    endcase
    prod = 29'(sum_sel) * 29'(recip(n_r));
    q    = prod[RECIP_SHIFT+7:RECIP_SHIFT];
    fill = (ctr_r[31:24] == 8'd0) && (n_r != 4'd0);
  end

  tpnf_ram #(.WIDTH(32), .DEPTH(S)) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && pix),
    .wr_addr (wr_pos_r),
    .wr_data (in_pix),
    .rd_en   (cmd.issue),
    .rd_addr (tap_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_W_BITS'(WIDTH_RST);
      height_r    <= CFG_H_BITS'(HEIGHT_RST);
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      pending_r   <= '0;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      dr_r        <= '0;
      dc_r        <= '0;
      ch_r        <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data[CFG_W_BITS-1:0];
      else height_r <= cfg_data[CFG_H_BITS-1:0];
      wr_pos_r  <= '0;
      rd_pos_r  <= '0;
      pending_r <= '0;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      if (out_tready) out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && pix) begin
        wr_pos_r  <= (32'(wr_pos_r) == S - 1) ? '0 : wr_pos_r + AW'(1);
        pending_r <= pending_r + PW'(1);
        if (32'(in_col_r) + 32'd1 >= 32'(eff_w)) begin
          in_col_r <= '0;
          in_row_r <= (32'(in_row_r) + 32'd1 >= 32'(eff_h)) ? '0 : in_row_r + HW'(1);
        end else begin
          in_col_r <= in_col_r + WW'(1);
        end
      end
      if (cmd.start) begin
        dr_r <= '0;
        dc_r <= '0;
        ch_r <= '0;
        n_r  <= '0;
      end
      if (cmd.accum) begin
        if (tap_in && rd_data[31:24] == OPAQUE) n_r <= n_r + 4'd1;
        if (dc_r == 2'd2) begin
          dc_r <= '0;
          dr_r <= dr_r + 2'd1;
        end else begin
          dc_r <= dc_r + 2'd1;
        end
      end
      if (cmd.div_step) ch_r <= ch_r + 2'd1;
      if (cmd.load) begin
        out_valid_r <= 1'b1;
        rd_pos_r    <= (32'(rd_pos_r) == S - 1) ? '0 : rd_pos_r + AW'(1);
        pending_r   <= pending_r - PW'(1);
        if (32'(out_col_r) + 32'd1 >= 32'(eff_w)) begin
          out_col_r <= '0;
          out_row_r <= (32'(out_row_r) + 32'd1 >= 32'(eff_h)) ? '0 : out_row_r + HW'(1);
        end else begin
          out_col_r <= out_col_r + WW'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rb_r <= rb_init[AW-1:0];
      sr_r <= '0;
      sg_r <= '0;
      sb_r <= '0;
    end
    if (cmd.accum) begin
      if (tap_in && rd_data[31:24] == OPAQUE) begin
        sr_r <= sr_r + 12'(rd_data[7:0]);
        sg_r <= sg_r + 12'(rd_data[15:8]);
        sb_r <= sb_r + 12'(rd_data[23:16]);
      end
      if (dr_r == 2'd1 && dc_r == 2'd1) ctr_r <= rd_data;
      if (dc_r == 2'd2) rb_r <= rb_sum[AW-1:0];
    end
    if (cmd.div_step) begin
      case (ch_r)
        2'd0:    qr_r <= q;
        2'd1:    qg_r <= q;
        default: qb_r <= q;
      endcase
    end
    if (cmd.load) begin
      out_data_r <= {ctr_r[31:24], fill ? qb_r : ctr_r[23:16],
                     fill ? qg_r : ctr_r[15:8], fill ? qr_r : ctr_r[7:0]};
      out_last_r <= (32'(out_row_r) + 32'd1 == 32'(eff_h))
                 && (32'(out_col_r) + 32'd1 == 32'(eff_w));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_pending_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pending_r) <= MAX_WIDTH + 2)
    else $error("pending count overran the window span");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 4'd9)
    else $error("opaque count above nine");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !cfg_write |=> out_tvalid)
    else $error("loaded result not presented");

endmodule

/* hw/rtl/transparent_pixel_neighbor_fill_core.sv */
// Flow: a result leaves one row plus one pixel behind its input; the item that
//   triggers it is taken, the 3x3 taps are walked through the single read port of
//   the line store, the channels are divided, and the result loads once the output is free.
// Items without a result are taken back to back; input waits while a result is made.
// Reset (rst_n low, synchronous): width and height return to 64, all positions
//   and counts clear; the line store keeps its contents and needs no clearing.
module transparent_pixel_neighbor_fill_core
  import tpnf_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write channel: index 0 image_width, 1 image_height
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // pixel input
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [31:0]              in_tdata,   // in_red, in_green, in_blue, in_alpha
  input  logic                     in_tuser,   // kind: 0 pixel, 1 flush
  // pixel output
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [31:0]              out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                     out_tlast   // frame_end
);

  tpnf_cmd_t cmd;
  tpnf_sts_t sts;

  // Users write registers only between frames (unenforced); take every transfer at once.
  assign cfg_ready = 1'b1;

  // Controller: walks each emitted pixel through tap reads, divide, and load.
  tpnf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: line store, position counters, accumulators, reciprocal divide,
  // and the output register that holds a result until its transfer.
  tpnf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (in_tuser),
    .in_pix     (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* sim/transparent_pixel_neighbor_fill_core_tb.sv */
`timescale 1ns / 100ps

module transparent_pixel_neighbor_fill_core_tb;
  import tpnf_pkg::*;

  localparam int LINE_DEPTH   = 2 * MAX_WIDTH_DEF + 4;
  localparam int SETTLE_CYC   = 40;     // covers the walk of a last result
  localparam int STALL_LIMIT  = 2000;   // cycles with no transfer on any channel

  typedef struct packed {
    logic [31:0] px;
    logic        last;
  } filled_px_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [31:0]              in_tdata;   // in_red, in_green, in_blue, in_alpha
  logic                     in_tuser;   // kind: 0 pixel, 1 flush
  logic                     out_tvalid;
  logic                     out_tready;
  logic [31:0]              out_tdata;  // out_red, out_green, out_blue, out_alpha
  logic                     out_tlast;  // frame_end

  transparent_pixel_neighbor_fill_core dut (.*);

  // Shadow of the fill logic: registers, line store and stream positions.
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [31:0] line_mem [LINE_DEPTH];
  int          in_col, in_row, out_col, out_row, wr_ptr, rd_ptr, held;
  filled_px_t  fill_q [$];

  int  errors;
  int  sent_items;
  bit  calm;          // no idling in the closing part of the run
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int frame_h();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return int'(height_reg);
  endfunction

  function automatic void restart_stream();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    wr_ptr = 0; rd_ptr = 0; held = 0;
  endfunction

  // Average the opaque taps into the oldest held pixel if it is transparent; queue it.
  function automatic void fill_oldest();
    int         w, h, n, sr, sg, sb, idx;
    logic [31:0] tap, centre;
    filled_px_t r;
    w = frame_w();
    h = frame_h();
    n = 0; sr = 0; sg = 0; sb = 0;
    centre = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if ((dr == 0 && out_row == 0) || (dr == 2 && out_row + 1 >= h) ||
            (dc == 0 && out_col == 0) || (dc == 2 && out_col + 1 >= w))
          continue;
        idx = (rd_ptr + LINE_DEPTH + dr * w + dc - w - 1) % LINE_DEPTH;
        tap = line_mem[idx];
        if (dr == 1 && dc == 1) centre = tap;
        if (tap[31:24] == OPAQUE) begin
          n++;
          sr += tap[7:0];
          sg += tap[15:8];
          sb += tap[23:16];
        end
      end
    end
    r.px = centre;
    if (centre[31:24] == 8'd0 && n != 0) begin
      r.px[7:0]   = 8'(sr / n);
      r.px[15:8]  = 8'(sg / n);
      r.px[23:16] = 8'(sb / n);
    end
    r.last = (out_row == h - 1 && out_col == w - 1);
    fill_q.push_back(r);
    rd_ptr = (rd_ptr + 1) % LINE_DEPTH;
    held--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endfunction

  function automatic void predict_item(logic kind, logic [31:0] px);
    int w, h;
    w = frame_w();
    h = frame_h();
    if (kind == KIND_PIXEL) begin
      line_mem[wr_ptr] = px;
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      held++;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) in_row = 0;
      end
      if (held > w + 1) fill_oldest();
    end else if (held > 0 && in_col == 0 && in_row == 0) begin
      fill_oldest();
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Check results, track accepted items and configuration writes, watch for hangs.
  always @(posedge clk) begin
    filled_px_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (fill_q.size() == 0) begin
          report_mismatch("unexpected pixel", out_tdata, 32'd0);
        end else begin
          want = fill_q.pop_front();
          if (out_tdata[7:0] !== want.px[7:0])
            report_mismatch("red", 32'(out_tdata[7:0]), 32'(want.px[7:0]));
          if (out_tdata[15:8] !== want.px[15:8])
            report_mismatch("green", 32'(out_tdata[15:8]), 32'(want.px[15:8]));
          if (out_tdata[23:16] !== want.px[23:16])
            report_mismatch("blue", 32'(out_tdata[23:16]), 32'(want.px[23:16]));
          if (out_tdata[31:24] !== want.px[31:24])
            report_mismatch("alpha", 32'(out_tdata[31:24]), 32'(want.px[31:24]));
          if (out_tlast !== want.last)
            report_mismatch("frame_end", 32'(out_tlast), 32'(want.last));
        end
      end
      if (in_tvalid && in_tready) predict_item(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH) width_reg = cfg_data[10:0];
        else                        height_reg = cfg_data[12:0];
        restart_stream();
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result side: stall in short random bursts until the closing part.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Hold one item until its transfer, then maybe drop valid for a burst.
  task automatic send_item(logic kind, logic [31:0] px);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Drop valid, wait out every queued result plus the walk of a last one.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fill_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h);
    settle();
    write_reg(REG_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_HEIGHT, CFG_DATA_BITS'(h));
  endtask

  function automatic logic [31:0] rand_px();
    logic [7:0] a;
    case ($urandom_range(0, 4))
      0, 1:    a = 8'd0;
      2, 3:    a = OPAQUE;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  // Drain a finished frame: flushes only count once input is back at frame start.
  task automatic drain(int w);
    for (int i = 0; i < w + 2; i++) send_item(KIND_FLUSH, $urandom);
  endtask

  // 3x3 frame with channel extremes, a flush mid-frame and a full drain.
  task automatic test_small_frame();
    logic [31:0] pix [9];
    pix = '{ {OPAQUE, 8'hFF, 8'hFF, 8'hFF}, 32'h0000_0000, {OPAQUE, 24'h0},
             32'h00FF_FFFF, 32'h0012_3456, {8'd128, 24'hABCDEF},
             {OPAQUE, 24'h80FF01}, 32'h0000_0000, {8'd254, 24'h010203} };
    set_frame(3, 3);
    for (int i = 0; i < 9; i++) begin
      send_item(KIND_PIXEL, pix[i]);
      if (i == 4) send_item(KIND_FLUSH, 32'hFFFF_FFFF);
    end
    drain(3);
  endtask

  // Degenerate sizes: 1x1, width zero, height zero, all transparent alone, and a 2x1 frame.
  task automatic test_tiny_frames();
    set_frame(1, 1);
    send_item(KIND_PIXEL, 32'h0055_AA33);
    send_item(KIND_PIXEL, {OPAQUE, 24'h102030});
    drain(1);
    set_frame(0, 0);
    send_item(KIND_PIXEL, 32'h0000_00FF);
    drain(1);
    set_frame(2, 1);
    send_item(KIND_PIXEL, {OPAQUE, 24'hFFFFFF});
    send_item(KIND_PIXEL, 32'h0000_0000);
    drain(2);
  endtask

  // Oversized registers clamp to the maximum frame size; a full clamped row
  // plus two pixels is just enough to release the first result.
  task automatic test_clamped_sizes();
    set_frame(2047, 2);
    for (int i = 0; i < MAX_WIDTH_DEF + 2; i++) send_item(KIND_PIXEL, rand_px());
    settle();
    set_frame(4, 8191);
    for (int i = 0; i < 20; i++) send_item(KIND_PIXEL, rand_px());
    settle();   // partial frame: the next write discards what is still held
  endtask

  // Back-to-back frames of random small sizes, with stray flushes as noise.
  task automatic test_random_frames(int budget);
    int w, h, frames;
    while (sent_items < budget) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_frame(w, h);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        for (int i = 0; i < w * h; i++) begin
          if ($urandom_range(0, 9) == 0) send_item(KIND_FLUSH, $urandom);
          send_item(KIND_PIXEL, rand_px());
        end
      if ($urandom_range(0, 4) == 0)
        for (int i = 0; i < w; i++) send_item(KIND_PIXEL, rand_px());  // cut short
      else
        drain(w);
      if (sent_items > budget - 300) calm = 1'b1;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_WIDTH;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_PIXEL;
    width_reg  = 11'(WIDTH_RST);
    height_reg = 13'(HEIGHT_RST);
    for (int i = 0; i < LINE_DEPTH; i++) line_mem[i] = '0;
    restart_stream();
    errors = 0;
    sent_items = 0;
    calm = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_frame();
    test_tiny_frames();
    test_clamped_sizes();
    test_random_frames(sent_items + 600);

    settle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
